>>> src/ifse_pkg.sv
`timescale 1ns / 1ps

package ifse_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;
  localparam int CFG_W  = 8;
  localparam int CIDX_W = 3;
  localparam int OFS_W  = 6;

  // register map of the configuration port
  typedef enum logic [CIDX_W-1:0] {
    CFG_HEADER_FIRST  = 3'd0,
    CFG_HEADER_SECOND = 3'd1,
    CFG_MARKER_OFFSET = 3'd2,
    CFG_MARKER_VALUE  = 3'd3,
    CFG_OVERFLOW_LIM  = 3'd4
  } cfg_idx_t;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h0E;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h04;
  localparam logic [OFS_W-1:0]  MARKER_OFFSET_RST = 6'd15;
  localparam logic [BYTE_W-1:0] MARKER_VALUE_RST  = 8'h05;
  localparam logic [CFG_W-1:0]  OVERFLOW_LIM_RST  = 8'd200;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MARK,
    ST_MARK_WAIT,
    ST_EMIT_RD,
    ST_EMIT_LOAD,
    ST_MOVE,
    ST_FINISH
  } state_t;

endpackage

>>> src/imu_frame_sync_extractor_core.sv
`timescale 1ns / 1ps

// Frame synchronizer for a serial IMU byte stream. Each received byte is taken while the
// core is idle and appended to a buffer RAM (BUFFER_DEPTH bytes, one read and one write
// port) unless the buffer is full. Once the buffer holds FRAME_LEN bytes or more, every
// byte starts a scan that reads the buffer one entry per cycle through the single read port.
// When the first header has a full frame behind it and its marker byte matches, the frame
// goes out as FRAME_LEN words (index 0 up, tlast on the final one), each read from the
// buffer and then loaded when the output is free; then the bytes behind it are copied to
// the front at one per cycle. The buffer needs no clearing after reset. A new byte is taken
// while the final word of a frame still waits at the output.
module imu_frame_sync_extractor_core #(
  parameter int FRAME_LEN    = 46,
  parameter int BUFFER_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // slave side: rx_byte[7:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // master side: frame_byte[7:0], byte_index[13:8], zero[15:14]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic        m_tlast,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam int IW = ifse_pkg::IDX_W;
  localparam int BW = ifse_pkg::BYTE_W;
  localparam int CW = (FW > ifse_pkg::CFG_W) ? FW : ifse_pkg::CFG_W;
  localparam logic [FW-1:0] DEPTH_F  = FW'(BUFFER_DEPTH);
  localparam logic [FW-1:0] FL_F     = FW'(FRAME_LEN);
  localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_LEN - 1);
  localparam logic [IW:0]   FL_CMP   = (IW + 1)'(FRAME_LEN);
  localparam logic [CW-1:0] DEPTH_C  = CW'(BUFFER_DEPTH);

  ifse_pkg::state_t state, state_next;

  logic [BW-1:0] header_first, header_second, marker_value;
  logic [ifse_pkg::OFS_W-1:0] marker_offset;
  logic [ifse_pkg::CFG_W-1:0] overflow_limit;

  logic [FW-1:0] fill;
  logic [FW-1:0] scan_addr;
  logic          dvalid;
  logic [FW-1:0] daddr;
  logic [BW-1:0] prev;
  logic [FW-1:0] hdr_pos;
  logic [FW-1:0] rest;
  logic [IW-1:0] k;
  logic [FW-1:0] rcnt, wcnt;
  logic          mpend;

  logic [BW-1:0] out_byte;
  logic [IW-1:0] out_idx;
  logic          out_last;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [BW-1:0] ram_wdata, ram_rdata;

  logic          hit;
  logic          out_free;
  logic [FW-1:0] mark_addr, emit_addr, move_addr;
  logic [CW-1:0] limit, fill_c;

  ifse_ram #(.WIDTH(BW), .DEPTH(BUFFER_DEPTH)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hit       = dvalid && (daddr != '0) && (prev == header_first)
                     && (ram_rdata == header_second);
  assign out_free  = !m_tvalid || m_tready;
  assign mark_addr = hdr_pos + FW'(marker_offset);
  assign emit_addr = hdr_pos + FW'(k);
  assign move_addr = hdr_pos + FL_F + rcnt;
  assign limit     = (CW'(overflow_limit) > DEPTH_C) ? DEPTH_C : CW'(overflow_limit);
  assign fill_c    = CW'(fill);

  assign m_tdata = {2'b00, out_idx, out_byte};
  assign m_tlast = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ifse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = fill[AW-1:0];
    ram_wdata  = s_tdata;
    ram_re     = 1'b0;
    ram_raddr  = scan_addr[AW-1:0];
    unique case (state)
      ifse_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ram_we     = (fill < DEPTH_F);
          state_next = ifse_pkg::ST_CHECK;
        end
      end
      ifse_pkg::ST_CHECK: begin
        state_next = (fill >= FL_F) ? ifse_pkg::ST_SCAN : ifse_pkg::ST_FINISH;
      end
      ifse_pkg::ST_SCAN: begin
        ram_re = (scan_addr < fill);
        if (hit) begin
          state_next = ifse_pkg::ST_MARK;
        end else if (dvalid && (daddr == fill - FW'(1))) begin
          state_next = ifse_pkg::ST_FINISH;
        end
      end
      ifse_pkg::ST_MARK: begin
        ram_raddr = mark_addr[AW-1:0];
        if ((fill - hdr_pos >= FL_F) && ({1'b0, marker_offset} < FL_CMP)) begin
          ram_re     = 1'b1;
          state_next = ifse_pkg::ST_MARK_WAIT;
        end else begin
          state_next = ifse_pkg::ST_FINISH;
        end
      end
      ifse_pkg::ST_MARK_WAIT: begin
        state_next = (ram_rdata == marker_value) ? ifse_pkg::ST_EMIT_RD
                                                 : ifse_pkg::ST_FINISH;
      end
      ifse_pkg::ST_EMIT_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = emit_addr[AW-1:0];
        state_next = ifse_pkg::ST_EMIT_LOAD;
      end
      ifse_pkg::ST_EMIT_LOAD: begin
        if (out_free) begin
          if (k != LAST_IDX) begin
            state_next = ifse_pkg::ST_EMIT_RD;
          end else begin
            state_next = (rest == '0) ? ifse_pkg::ST_FINISH : ifse_pkg::ST_MOVE;
          end
        end
      end
      ifse_pkg::ST_MOVE: begin
        // reads run one entry ahead of the writes, source always above destination
        ram_re    = (rcnt < rest);
        ram_raddr = move_addr[AW-1:0];
        ram_we    = mpend;
        ram_waddr = wcnt[AW-1:0];
        ram_wdata = ram_rdata;
        if (mpend && (wcnt == rest - FW'(1))) begin
          state_next = ifse_pkg::ST_FINISH;
        end
      end
      ifse_pkg::ST_FINISH: begin
        state_next = ifse_pkg::ST_IDLE;
      end
      default: begin
        state_next = ifse_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill           <= '0;
      m_tvalid       <= 1'b0;
      dvalid         <= 1'b0;
      mpend          <= 1'b0;
      header_first   <= ifse_pkg::HEADER_FIRST_RST;
      header_second  <= ifse_pkg::HEADER_SECOND_RST;
      marker_offset  <= ifse_pkg::MARKER_OFFSET_RST;
      marker_value   <= ifse_pkg::MARKER_VALUE_RST;
      overflow_limit <= ifse_pkg::OVERFLOW_LIM_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ifse_pkg::CFG_HEADER_FIRST:  header_first   <= cfg_data;
          ifse_pkg::CFG_HEADER_SECOND: header_second  <= cfg_data;
          ifse_pkg::CFG_MARKER_OFFSET: marker_offset  <= cfg_data[ifse_pkg::OFS_W-1:0];
          ifse_pkg::CFG_MARKER_VALUE:  marker_value   <= cfg_data;
          ifse_pkg::CFG_OVERFLOW_LIM:  overflow_limit <= cfg_data;
          default: ;
        endcase
      end

      // a word loaded in the same cycle keeps tvalid high
      if (m_tvalid && m_tready && !((state == ifse_pkg::ST_EMIT_LOAD) && out_free)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ifse_pkg::ST_IDLE: begin
          if (s_tvalid && (fill < DEPTH_F)) begin
            fill <= fill + FW'(1);
          end
        end
        ifse_pkg::ST_CHECK: begin
          scan_addr <= '0;
          dvalid    <= 1'b0;
        end
        ifse_pkg::ST_SCAN: begin
          dvalid <= ram_re;
          daddr  <= scan_addr;
          if (ram_re) begin
            scan_addr <= scan_addr + FW'(1);
          end
          if (dvalid) begin
            prev <= ram_rdata;
          end
          if (hit) begin
            hdr_pos <= daddr - FW'(1);
          end
        end
        ifse_pkg::ST_MARK: begin
          rest <= fill - hdr_pos - FL_F;
          k    <= '0;
        end
        ifse_pkg::ST_EMIT_LOAD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            out_byte <= ram_rdata;
            out_idx  <= k;
            out_last <= (k == LAST_IDX);
            k        <= k + IW'(1);
            if (k == LAST_IDX) begin
              fill  <= rest;
              rcnt  <= '0;
              wcnt  <= '0;
              mpend <= 1'b0;
            end
          end
        end
        ifse_pkg::ST_MOVE: begin
          mpend <= ram_re;
          if (ram_re) begin
            rcnt <= rcnt + FW'(1);
          end
          if (mpend) begin
            wcnt <= wcnt + FW'(1);
          end
        end
        ifse_pkg::ST_FINISH: begin
          if (fill_c >= limit) begin
            fill <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> src/ifse_ram.sv
`timescale 1ns / 1ps

module ifse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/ifse_checker.sv
`timescale 1ns / 1ps

module ifse_checker #(
  parameter int FRAME_LEN = 46
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  localparam int IW = ifse_pkg::IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_LEN - 1);

  // index the next output word must carry
  logic [IW-1:0] exp_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (m_tvalid && m_tready) begin
      exp_idx <= m_tlast ? '0 : m_tdata[13:8] + IW'(1);
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("input word changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_idx_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13:8] == exp_idx) && (m_tdata[15:14] == 2'b00))
    else $error("frame word index out of order");

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[13:8] == LAST_IDX)))
    else $error("tlast not on final frame word");

  a_no_rx_mid_frame: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (exp_idx == '0) || (m_tvalid && m_tlast))
    else $error("byte taken in the middle of a frame");

endmodule

bind imu_frame_sync_extractor_core ifse_checker #(.FRAME_LEN(FRAME_LEN)) u_ifse_checker (.*);
